// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define CHK_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: design/ipv4hc_pkg.sv
// ----------------------------------------------------------------------------
// ipv4hc_pkg
// Types and constants of the IPv4 header checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ipv4hc_pkg;

	localparam logic [7:0]  IHL_MASK     = 8'h0F;
	localparam logic [7:0]  VERSION_MASK = 8'hF0;
	localparam logic [15:0] FRAG_MASK    = 16'hBFFF;
	localparam logic [3:0]  IP_VER       = 4'd4;
	localparam logic [3:0]  IHL_MIN      = 4'd5;
	localparam logic [15:0] SUM_GOOD     = 16'hFFFF;

	localparam logic [7:0] PROTO_ICMP = 8'd1;
	localparam logic [7:0] PROTO_TCP  = 8'd6;
	localparam logic [7:0] PROTO_UDP  = 8'd17;

	localparam logic [5:0] MIN_HDR_BYTES = 6'd20;

	typedef enum logic [2:0] {
		V_ICMP  = 3'd0,
		V_TCP   = 3'd1,
		V_UDP   = 3'd2,
		V_UNSUP = 3'd3,
		V_CSUM  = 3'd4,
		V_VER   = 3'd5,
		V_FRAG  = 3'd6,
		V_SHORT = 3'd7
	} verdict_t;

	typedef struct packed {
		verdict_t    verdict;
		logic [7:0]  protocol;
		logic [5:0]  header_bytes;
		logic [15:0] total_length;
		logic [31:0] source_addr;
		logic [31:0] dest_addr;
	} result_t;

endpackage

// File: design/ipv4hc_if.sv
// ----------------------------------------------------------------------------
// ipv4hc_if
// Valid/ready channels: datagram bytes in, header verdicts out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ipv4hc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       first_byte;

	modport source (output valid, data_byte, first_byte, input ready);
	modport sink (input valid, data_byte, first_byte, output ready);
endinterface

interface ipv4hc_verdict_if;
	logic        valid;
	logic        ready;
	logic [2:0]  verdict;
	logic [7:0]  protocol;
	logic [5:0]  header_bytes;
	logic [15:0] total_length;
	logic [31:0] source_addr;
	logic [31:0] dest_addr;

	modport source (output valid, verdict, protocol, header_bytes, total_length,
		source_addr, dest_addr, input ready);
	modport sink (input valid, verdict, protocol, header_bytes, total_length,
		source_addr, dest_addr, output ready);
endinterface

// File: design/ipv4hc_core.sv
// ----------------------------------------------------------------------------
// ipv4hc_core
// Header parse state, ones' complement sum and verdict logic, one byte a step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ipv4hc_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [7:0]           data_byte,
	input  logic                 first_byte,
	output logic                 res_valid,
	output ipv4hc_pkg::result_t  res
);

	logic [5:0]  byte_index_q;
	logic        in_header_q;
	logic [15:0] sum_accum_q;
	logic [7:0]  high_byte_q;
	logic [7:0]  version_ihl_q;
	logic [15:0] length_q;
	logic [15:0] flags_offset_q;
	logic [7:0]  protocol_q;
	logic [31:0] source_q;
	logic [31:0] dest_q;

	logic        active;
	logic [5:0]  idx;
	logic [7:0]  vihl;
	logic        short_hdr;
	logic        last;
	logic [5:0]  hlen;
	logic [15:0] sum_base;
	logic [7:0]  high_base;
	logic [16:0] sum_wide;
	logic [15:0] sum_new;
	logic [15:0] length_new;
	logic [15:0] flags_new;
	logic [7:0]  protocol_new;
	logic [31:0] source_new;
	logic [31:0] dest_new;
	ipv4hc_pkg::verdict_t verdict;

	assign active    = first_byte | in_header_q;
	assign idx       = first_byte ? 6'd0 : byte_index_q;
	assign vihl      = (idx == 6'd0) ? data_byte : version_ihl_q;
	assign hlen      = {vihl[3:0], 2'b00};
	assign short_hdr = active && (idx == 6'd0)
		&& ((data_byte & ipv4hc_pkg::IHL_MASK) < {4'd0, ipv4hc_pkg::IHL_MIN});
	assign last      = active && !short_hdr && (({1'b0, idx} + 7'd1) >= {1'b0, hlen});

	assign sum_base  = first_byte ? 16'd0 : sum_accum_q;
	assign high_base = first_byte ? 8'd0 : high_byte_q;
	assign sum_wide  = {1'b0, sum_base} + {1'b0, high_base, data_byte};
	assign sum_new   = sum_wide[15:0] + {15'd0, sum_wide[16]};

	always_comb begin
		length_new   = first_byte ? 16'd0 : length_q;
		flags_new    = first_byte ? 16'd0 : flags_offset_q;
		protocol_new = first_byte ? 8'd0 : protocol_q;
		source_new   = first_byte ? 32'd0 : source_q;
		dest_new     = first_byte ? 32'd0 : dest_q;
		case (idx)
			6'd2, 6'd3: length_new = {length_new[7:0], data_byte};
			6'd6, 6'd7: flags_new = {flags_new[7:0], data_byte};
			6'd9: protocol_new = data_byte;
			6'd12, 6'd13, 6'd14, 6'd15: source_new = {source_new[23:0], data_byte};
			6'd16, 6'd17, 6'd18, 6'd19: dest_new = {dest_new[23:0], data_byte};
			default: ;
		endcase
	end

	always_comb begin
		if (short_hdr) begin
			verdict = ipv4hc_pkg::V_SHORT;
		end else if (sum_new != ipv4hc_pkg::SUM_GOOD) begin
			verdict = ipv4hc_pkg::V_CSUM;
		end else if ((vihl & ipv4hc_pkg::VERSION_MASK) != {ipv4hc_pkg::IP_VER, 4'd0}) begin
			verdict = ipv4hc_pkg::V_VER;
		end else if ((flags_new & ipv4hc_pkg::FRAG_MASK) != 16'd0) begin
			verdict = ipv4hc_pkg::V_FRAG;
		end else if (protocol_new == ipv4hc_pkg::PROTO_ICMP) begin
			verdict = ipv4hc_pkg::V_ICMP;
		end else if (protocol_new == ipv4hc_pkg::PROTO_TCP) begin
			verdict = ipv4hc_pkg::V_TCP;
		end else if (protocol_new == ipv4hc_pkg::PROTO_UDP) begin
			verdict = ipv4hc_pkg::V_UDP;
		end else begin
			verdict = ipv4hc_pkg::V_UNSUP;
		end
	end

	assign res_valid         = step && (short_hdr || last);
	assign res.verdict       = verdict;
	assign res.header_bytes  = hlen;
	assign res.protocol      = short_hdr ? 8'd0 : protocol_new;
	assign res.total_length  = short_hdr ? 16'd0 : length_new;
	assign res.source_addr   = short_hdr ? 32'd0 : source_new;
	assign res.dest_addr     = short_hdr ? 32'd0 : dest_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q   <= 6'd0;
			in_header_q    <= 1'b0;
			sum_accum_q    <= 16'd0;
			high_byte_q    <= 8'd0;
			version_ihl_q  <= 8'd0;
			length_q       <= 16'd0;
			flags_offset_q <= 16'd0;
			protocol_q     <= 8'd0;
			source_q       <= 32'd0;
			dest_q         <= 32'd0;
		end else if (step && active) begin
			version_ihl_q  <= vihl;
			length_q       <= length_new;
			flags_offset_q <= flags_new;
			protocol_q     <= protocol_new;
			source_q       <= source_new;
			dest_q         <= dest_new;
			if (short_hdr) begin
				in_header_q  <= 1'b0;
				byte_index_q <= 6'd0;
				sum_accum_q  <= sum_base;
				high_byte_q  <= high_base;
			end else begin
				sum_accum_q  <= idx[0] ? sum_new : sum_base;
				high_byte_q  <= idx[0] ? high_base : data_byte;
				in_header_q  <= !last;
				byte_index_q <= last ? 6'd0 : idx + 6'd1;
			end
		end
	end

endmodule

// File: design/ipv4_header_checker.sv
// IPv4 header checker.
// A verdict is offered from the result register once the last header byte has passed the input register and core.
// Throughput: one byte per cycle unless a held result stalls the input, set by the single-pass sum and verdict logic.
// Input and result registers; a held result stalls the input, otherwise no bubbles.
// Reset: arst_n clears parse state and both pipeline valids; block comes up idle.
// ----------------------------------------------------------------------------
// ipv4_header_checker
// Input register, header core and verdict output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ipv4_header_checker (
	input  logic                    clk,
	input  logic                    arst_n,
	ipv4hc_byte_if.sink             ingress,
	ipv4hc_verdict_if.source        egress
);

	logic                valid_s1;
	logic [7:0]          data_s1;
	logic                first_s1;
	logic                valid_s2;
	ipv4hc_pkg::result_t res_s2;

	logic                advance;
	logic                step;
	logic                core_valid;
	ipv4hc_pkg::result_t core_res;

	logic                out_short;
	logic                out_full;
	logic                short_zero;
	logic                full_len_ok;

	assign advance       = !valid_s2 || egress.ready;
	assign ingress.ready = !valid_s1 || advance;
	assign step          = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ingress.ready) begin
			valid_s1 <= ingress.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ingress.ready && ingress.valid) begin
			data_s1  <= ingress.data_byte;
			first_s1 <= ingress.first_byte;
		end
	end

	ipv4hc_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.data_byte  (data_s1),
		.first_byte (first_s1),
		.res_valid  (core_valid),
		.res        (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= core_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && core_valid) begin
			res_s2 <= core_res;
		end
	end

	assign egress.valid        = valid_s2;
	assign egress.verdict      = res_s2.verdict;
	assign egress.protocol     = res_s2.protocol;
	assign egress.header_bytes = res_s2.header_bytes;
	assign egress.total_length = res_s2.total_length;
	assign egress.source_addr  = res_s2.source_addr;
	assign egress.dest_addr    = res_s2.dest_addr;

	assign out_short   = valid_s2 && (res_s2.verdict == ipv4hc_pkg::V_SHORT);
	assign out_full    = valid_s2 && (res_s2.verdict != ipv4hc_pkg::V_SHORT);
	assign short_zero  = (res_s2.source_addr == 32'd0) && (res_s2.dest_addr == 32'd0)
		&& (res_s2.total_length == 16'd0);
	assign full_len_ok = res_s2.header_bytes >= ipv4hc_pkg::MIN_HDR_BYTES;

	`CHK_IMPL(a_ready_when_out_free, clk, arst_n, !valid_s2, ingress.ready)
	`CHK_IMPL(a_core_only_on_step, clk, arst_n, core_valid, step)
	`CHK_IMPL(a_short_fields_zero, clk, arst_n, out_short, short_zero)
	`CHK_IMPL(a_full_hdr_len, clk, arst_n, out_full, full_len_ok)
	`CHK_NEXT(a_result_lands, clk, arst_n, core_valid && advance, valid_s2)

endmodule
